// File: hdl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, switched off while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, switched off while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Property that holds at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: hdl/rgbm_pkg.sv
// ---------------------------------------------------------------------------
// rgbm_pkg
// Types and constants shared by the RGB 3x3 median filter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbm_pkg;

    localparam int WIN_N  = 9;      // cells in the 3x3 window
    localparam int FW_W   = 11;     // frame_width register width
    localparam int FH_W   = 12;     // frame_height register width, also row counters
    localparam int CFG_W  = 12;     // config data width

    localparam logic [FH_W-1:0] ROW_LIMIT = 12'd4095;

    // register indexes on the config port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef t_pix [WIN_N-1:0] t_win;

endpackage

`default_nettype wire

// File: hdl/rgbm_ram.sv
// ---------------------------------------------------------------------------
// rgbm_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/rgbm_median.sv
// ---------------------------------------------------------------------------
// rgbm_median
// Rank-select median over the masked cells of a 3x3 window, per channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbm_median
    import rgbm_pkg::*;
(
    input  t_win              i_win,
    input  wire [WIN_N-1:0]   i_mask,
    input  wire [2:0]         i_rank,   // wanted rank in descending order
    output t_pix              o_pix
);

    logic [7:0] v     [3][WIN_N];
    logic [3:0] rank  [3][WIN_N];
    logic [7:0] res   [3];

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            v[0][i] = i_win[i].red;
            v[1][i] = i_win[i].green;
            v[2][i] = i_win[i].blue;
        end
        for (int ch = 0; ch < 3; ch++) begin
            res[ch] = 8'd0;
            for (int i = 0; i < WIN_N; i++) begin
                rank[ch][i] = 4'd0;
                for (int j = 0; j < WIN_N; j++) begin
                    // ties broken by cell position so each rank is unique
                    if (i_mask[j] && (j != i) &&
                        ((v[ch][j] > v[ch][i]) || ((v[ch][j] == v[ch][i]) && (j < i)))) begin
                        rank[ch][i] = rank[ch][i] + 4'd1;
                    end
                end
                if (i_mask[i] && (rank[ch][i] == {1'b0, i_rank})) begin
                    res[ch] = v[ch][i];
                end
            end
        end
        o_pix.red   = res[0];
        o_pix.green = res[1];
        o_pix.blue  = res[2];
    end

endmodule

`default_nettype wire

// File: hdl/rgb_median3x3_filter_core.sv
// RGB 3x3 median filter. Send one raster-order pixel per item; each result
// is the per-channel median of the in-frame 3x3 neighbors (lower median on
// an even count) and appears one row plus one pixel after its center pixel,
// so finish every frame with frame_width+1 items flagged drain in tuser.
// The core takes one item per clock; results pass the stage 1, stage 2 and
// output registers. It holds s_axis_tready low only while a result sits unread in
// the output register. The line store is a MAX_WIDTH x 48-bit RAM with one
// read and one write port; it needs no clearing pass. Write frame_width and
// frame_height only while the core is idle.
// ---------------------------------------------------------------------------
// rgb_median3x3_filter_core
// Streaming 3x3 median filter with two line stores and a sliding window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_median3x3_filter_core
    import rgbm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    // config write channel
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire              i_cfg_index,
    input  wire [CFG_W-1:0]  i_cfg_data,
    // pixel input
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire [23:0]       s_axis_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
    input  wire              s_axis_tuser,   // drain
    // median output
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic             m_axis_tlast    // last_of_frame
);

    localparam int CW   = $clog2(MAX_WIDTH);     // column counter width
    localparam int WW   = CW + 1;                // width value, up to MAX_WIDTH
    localparam int CMPW = (WW > FW_W) ? WW : FW_W;

    // ---------------- config registers ----------------
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 12'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
            endcase
        end
    end

    // clamp the frame size into the supported range
    logic [WW-1:0]   w;
    logic [FH_W-1:0] h;

    always_comb begin
        if (r_frame_width == '0) begin
            w = WW'(1);
        end else if (CMPW'(r_frame_width) > CMPW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_frame_width);
        end
        h = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic en;         // whole pipeline advances
    logic accept;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // ---------------- position control (accept stage) ----------------
    // Everything here depends on positions only, so decide it as the item
    // enters; the data stages then just follow the flags.
    logic [CW-1:0]   r_in_col,  n_in_col;
    logic [FH_W-1:0] r_in_row,  n_in_row;
    logic [CW-1:0]   r_out_col, n_out_col;
    logic [FH_W-1:0] r_out_row, n_out_row;

    logic             emit, last, use_before, col_wrap, out_wrap;
    logic [2:0]       row_ok, col_ok;
    logic [WIN_N-1:0] mask;
    logic [2:0]       k;

    always_comb begin
        emit     = (r_in_row >= FH_W'(2)) || ((r_in_row == FH_W'(1)) && (r_in_col != '0));
        col_wrap = ({1'b0, r_in_col} + WW'(1)) >= w;
        out_wrap = ({1'b0, r_out_col} + WW'(1)) >= w;
        last     = (r_out_row >= (h - FH_W'(1))) && ({1'b0, r_out_col} >= (w - WW'(1)));

        row_ok[0] = (r_out_row != '0);
        row_ok[1] = (r_out_row < h);
        row_ok[2] = (({1'b0, r_out_row} + 13'd1) < {1'b0, h});

        // at column zero the result belongs to the previous row's last
        // pixel: use the window before the shift, centered on its right column
        use_before = (r_in_col == '0);
        if (use_before) begin
            col_ok[0] = 1'b0;
            col_ok[1] = (r_out_col != '0);
            col_ok[2] = ({1'b0, r_out_col} < w);
        end else begin
            col_ok[0] = (r_out_col != '0);
            col_ok[1] = ({1'b0, r_out_col} < w);
            col_ok[2] = (({1'b0, r_out_col} + WW'(1)) < w);
        end

        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                mask[dr*3+dc] = row_ok[dr] && col_ok[dc];
            end
        end
        k = 3'($countones(mask) >> 1);

        // input position
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (col_wrap) begin
            n_in_col = '0;
            if (r_in_row < ROW_LIMIT) begin
                n_in_row = r_in_row + FH_W'(1);
            end
        end else begin
            n_in_col = r_in_col + CW'(1);
        end

        // output position
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_wrap) begin
                n_out_col = '0;
                if (r_out_row < ROW_LIMIT) begin
                    n_out_row = r_out_row + FH_W'(1);
                end
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---------------- stage 1: line store and window ----------------
    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [CW-1:0]    r_s1_xi;
    logic [WIN_N-1:0] r_s1_mask;
    logic             r_s1_before, r_s1_emit, r_s1_last;
    logic [2:0]       r_s1_k;
    logic             r_s1_fwd;
    logic [47:0]      r_fwd_data;
    t_pix             in_pix;

    logic [47:0] ram_q, entry, s1_wdata;
    t_pix        above1, above2;
    t_win        r_win, win_n, cand;

    assign in_pix = s_axis_tuser ? t_pix'(24'd0)
                                 : t_pix'{red:   s_axis_tdata[7:0],
                                          green: s_axis_tdata[15:8],
                                          blue:  s_axis_tdata[23:16]};

    // each line store entry holds {newer row, older row} for one column
    rgbm_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && en),
        .i_waddr (r_s1_xi),
        .i_wdata (s1_wdata),
        .i_re    (accept),
        .i_raddr (r_in_col),
        .o_rdata (ram_q)
    );

    always_comb begin
        // take the entry being written by the previous item when the
        // columns coincide (one-pixel frame width)
        entry  = r_s1_fwd ? r_fwd_data : ram_q;
        above2 = t_pix'(entry[23:0]);
        above1 = t_pix'(entry[47:24]);
        for (int dr = 0; dr < 3; dr++) begin
            win_n[dr*3+0] = r_win[dr*3+1];
            win_n[dr*3+1] = r_win[dr*3+2];
        end
        win_n[2] = above2;
        win_n[5] = above1;
        win_n[8] = r_s1_pix;
        s1_wdata = {r_s1_pix, above1};
        cand     = r_s1_before ? r_win : win_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s1_fwd   <= accept && r_s1_valid && (r_s1_xi == r_in_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= in_pix;
            r_s1_xi     <= r_in_col;
            r_s1_mask   <= mask;
            r_s1_before <= use_before;
            r_s1_emit   <= emit;
            r_s1_last   <= emit && last;
            r_s1_k      <= k;
            r_fwd_data  <= s1_wdata;
        end
    end

    // window: advance once per item, drop to zero after the frame's last output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid && en) begin
            r_win <= r_s1_last ? t_win'('0) : win_n;
        end
    end

    // ---------------- stage 2: selected neighbors ----------------
    logic             r_s2_valid;
    t_win             r_s2_win;
    logic [WIN_N-1:0] r_s2_mask;
    logic [2:0]       r_s2_k;
    logic             r_s2_last;
    t_pix             med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_win  <= cand;
            r_s2_mask <= r_s1_mask;
            r_s2_k    <= r_s1_k;
            r_s2_last <= r_s1_last;
        end
    end

    rgbm_median u_median (
        .i_win  (r_s2_win),
        .i_mask (r_s2_mask),
        .i_rank (r_s2_k),
        .o_pix  (med)
    );

    // ---------------- output register ----------------
    t_pix r_out_pix;
    logic r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pix  <= med;
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pix.blue, r_out_pix.green, r_out_pix.red};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: hdl/rgbm_checker.sv
// ---------------------------------------------------------------------------
// rgbm_checker
// Port-level checks for the RGB 3x3 median filter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgbm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_cfg_ready,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    // a stalled result holds its value
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // input side is open whenever the output register is free or drains
    `ASSERT_IMPLY(a_in_ready, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

    // input side closes only behind a stalled result
    `ASSERT_IMPLY(a_in_stall, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // no result straight after reset
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n) |-> !m_axis_tvalid)

    // config port never back-pressures once out of reset
    `ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)

endmodule

bind rgb_median3x3_filter_core rgbm_checker u_rgbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/rgb_median3x3_filter_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_median3x3_filter_core_tb
// Streams raster-order RGB frames of several sizes through the median core,
// predicts every per-channel 3x3 median with an in-bench line store and
// window, and checks each result item and its end-of-frame flag in order.
// ---------------------------------------------------------------------------

module rgb_median3x3_filter_core_tb;
    import rgbm_pkg::*;

    localparam int LINE_DEPTH = 1024;   // matches the core's MAX_WIDTH
    localparam int IDLE_LIMIT = 5000;   // cycles without any handshake
    localparam int LONG_HOLD  = 400;    // receiver hold-off to back the core up

    typedef struct {
        t_pix px;
        bit   drain;
    } pixel_item_t;

    typedef struct {
        t_pix px;
        bit   last;
    } median_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata = '0;   // in_red[7:0], in_green[15:8], in_blue[23:16]
    logic             s_axis_tuser = 1'b0; // drain
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;        // out_red[7:0], out_green[15:8], out_blue[23:16]
    logic             m_axis_tlast;        // last_of_frame

    rgb_median3x3_filter_core #(.MAX_WIDTH(LINE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Predictor state: register copies, line store, window and positions
    // -----------------------------------------------------------------------
    logic [FW_W-1:0] cfg_width  = 11'd640;
    logic [FH_W-1:0] cfg_height = 12'd480;
    t_pix line_mem [2*LINE_DEPTH];
    t_pix win [WIN_N];
    int   in_col, in_row, out_col, out_row;

    pixel_item_t pending [$];     // items waiting to be offered to the core
    median_t     medians_due [$]; // medians owed by the core, oldest first

    int  errors = 0;
    bit  in_fire = 1'b0;          // input item taken at the last rising edge
    bit  quiet = 1'b0;            // no idling on either side
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  src_gap = 0;
    int  sink_stall = 0;
    int  idle_cycles = 0;
    int  rand_items = 0;

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    // Descending insertion sort, take the element at n/2 (lower median on even n).
    function automatic logic [7:0] channel_median(input logic [7:0] v [WIN_N], input int n);
        logic [7:0] s [WIN_N];
        logic [7:0] t;
        int i, k;
        s = v;
        if (n <= 0) return 8'd0;
        for (i = 1; i < n; i++) begin
            t = s[i];
            k = i - 1;
            while (k >= 0 && s[k] < t) begin
                s[k+1] = s[k];
                k--;
            end
            s[k+1] = t;
        end
        return s[n/2];
    endfunction

    // Advance the window by one accepted item and queue the median it releases.
    task automatic predict_median(input pixel_item_t it);
        t_pix    prev_win [WIN_N];
        t_pix    src [WIN_N];
        t_pix    pix, a2, a1, p;
        logic [7:0] vr [WIN_N];
        logic [7:0] vg [WIN_N];
        logic [7:0] vb [WIN_N];
        int      w, h, x, y, xi, center, n, dr, dc, row, col, off;
        bit      emit;
        median_t m;
        w = eff_width();
        h = eff_height();
        x = in_col;
        y = in_row;
        n = 0;
        for (dr = 0; dr < WIN_N; dr++) begin
            vr[dr] = '0; vg[dr] = '0; vb[dr] = '0;
        end
        pix = it.drain ? '0 : it.px;   // a drain slot inside the frame counts as black
        emit = (y >= 2) || (y == 1 && x >= 1);
        prev_win = win;
        xi = (x < LINE_DEPTH) ? x : 0;
        a2 = line_mem[xi];
        a1 = line_mem[LINE_DEPTH + xi];
        for (dr = 0; dr < 3; dr++) begin
            win[dr*3+0] = win[dr*3+1];
            win[dr*3+1] = win[dr*3+2];
        end
        win[2] = a2;
        win[5] = a1;
        win[8] = pix;
        line_mem[xi] = a1;
        line_mem[LINE_DEPTH + xi] = pix;
        if (x + 1 >= w) begin
            in_col = 0;
            if (in_row < int'(ROW_LIMIT)) in_row = y + 1;   // saturate the row count
        end else begin
            in_col = x + 1;
        end
        if (!emit) return;

        // At column zero the median belongs to the previous row's last pixel,
        // whose neighborhood is the window prior to this shift.
        if (x == 0) begin
            src = prev_win;
            center = 2;
        end else begin
            src = win;
            center = 1;
        end
        for (dr = 0; dr < 3; dr++) begin
            row = out_row + dr - 1;
            if (row < 0 || row >= h) continue;
            for (dc = 0; dc < 3; dc++) begin
                off = dc - center;
                col = out_col + off;
                if (off < -1 || off > 1 || col < 0 || col >= w) continue;
                p = src[dr*3+dc];
                vr[n] = p.red;
                vg[n] = p.green;
                vb[n] = p.blue;
                n++;
            end
        end
        m.px.red   = channel_median(vr, n);
        m.px.green = channel_median(vg, n);
        m.px.blue  = channel_median(vb, n);
        m.last = (out_row >= h - 1) && (out_col >= w - 1);
        medians_due.push_back(m);

        if (m.last) begin
            // end of frame: positions and window start over
            for (dr = 0; dr < WIN_N; dr++) win[dr] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            if (out_row < int'(ROW_LIMIT)) out_row++;
        end else begin
            out_col++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Rising edge: take accepted items, check results, run the watchdog
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) predict_median(pending[0]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (medians_due.size() == 0) begin
                $display("%0t: unexpected result item, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                median_t m;
                m = medians_due.pop_front();
                if (m_axis_tdata[7:0] !== m.px.red)
                    $display("%0t: red mismatch, expected %h actual %h",
                             $time, m.px.red, m_axis_tdata[7:0]);
                if (m_axis_tdata[15:8] !== m.px.green)
                    $display("%0t: green mismatch, expected %h actual %h",
                             $time, m.px.green, m_axis_tdata[15:8]);
                if (m_axis_tdata[23:16] !== m.px.blue)
                    $display("%0t: blue mismatch, expected %h actual %h",
                             $time, m.px.blue, m_axis_tdata[23:16]);
                if (m_axis_tlast !== m.last)
                    $display("%0t: last_of_frame mismatch, expected %b actual %b",
                             $time, m.last, m_axis_tlast);
                if (m_axis_tdata !== {m.px.blue, m.px.green, m.px.red}
                    || m_axis_tlast !== m.last)
                    errors++;
            end
        end
        // Restart the idle count on any handshake or while in reset.
        if (in_fire || (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d medians outstanding", $time, medians_due.size());
            $display("rgb_median3x3_filter_core_tb: errors");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Pixel driver: falling edge, fed from the pending queue
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (in_fire) void'(pending.pop_front());
        if (src_gap > 0)
            src_gap--;
        else if (!quiet && (!s_axis_tvalid || in_fire) && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 9);   // never drop an item already on offer
        if (pending.size() != 0 && src_gap == 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {pending[0].px.blue, pending[0].px.green, pending[0].px.red};
            s_axis_tuser  <= pending[0].drain;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            sink_stall = LONG_HOLD;
            long_hold_done = 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(1, 9);
        end
        m_axis_tready <= (sink_stall == 0) && i_rst_n;
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == REG_FRAME_WIDTH) cfg_width = val[FW_W-1:0];
        else cfg_height = val[FH_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every item is taken and every median returned, then settle.
    task automatic wait_idle();
        while (pending.size() != 0 || medians_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    function automatic t_pix rand_pix();
        t_pix p;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            default: p = t_pix'(24'($urandom_range(0, 24'hFFFFFF)));
        endcase
        return p;
    endfunction

    // Queue one random frame plus its flush; returns the number of items.
    function automatic int queue_frame();
        pixel_item_t it;
        int w, h, i;
        w = eff_width();
        h = eff_height();
        for (i = 0; i < w * h + w + 1; i++) begin
            it.px = rand_pix();
            if (i < w * h)
                it.drain = ($urandom_range(0, 19) == 0);   // occasional black hole
            else
                it.drain = ($urandom_range(0, 9) != 0);    // sometimes a stray pixel
            pending.push_back(it);
        end
        return w * h + w + 1;
    endfunction

    task automatic queue_item(input logic [23:0] px, input bit drain);
        pixel_item_t it;
        it.px = t_pix'(px);
        it.drain = drain;
        pending.push_back(it);
    endtask

    initial begin
        for (int i = 0; i < 2 * LINE_DEPTH; i++) line_mem[i] = '0;
        for (int i = 0; i < WIN_N; i++) win[i] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed 3x3 frame: extremes, a drain inside the frame, a pixel in a
        // flush slot.
        set_frame(3, 3);
        queue_item(24'h000000, 0); queue_item(24'hFFFFFF, 0); queue_item(24'hFF00FF, 0);
        queue_item(24'h00FF00, 0); queue_item(24'hABCDEF, 1); queue_item(24'h123456, 0);
        queue_item(24'hFFFFFF, 0); queue_item(24'h000000, 0); queue_item(24'h808080, 0);
        queue_item(24'h000000, 1); queue_item(24'hFFFFFF, 0);
        queue_item(24'h000000, 1); queue_item(24'h000000, 1);

        // Zero width and height act as one pixel; 2x2 gives even neighbor counts.
        set_frame(0, 0);
        void'(queue_frame());
        set_frame(2, 2);
        queue_item(24'hFF0000, 0); queue_item(24'h00FF00, 0);
        queue_item(24'h0000FF, 0); queue_item(24'h7F7F7F, 0);
        queue_item(24'h0, 1); queue_item(24'h0, 1); queue_item(24'h0, 1);

        // Long receiver hold-off while the sender keeps offering.
        set_frame(8, 6);
        long_hold_req = 1'b1;
        rand_items += queue_frame();

        // Random frames, mostly small; no idling in the final stretch.
        while (rand_items < 1750) begin
            if (rand_items > 1450) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                set_frame(CFG_W'($urandom_range(9, 40)), CFG_W'($urandom_range(1, 4)));
            else
                set_frame(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 6)));
            rand_items += queue_frame();
        end

        wait_idle();
        if (errors == 0)
            $display("rgb_median3x3_filter_core_tb: clean");
        else
            $display("rgb_median3x3_filter_core_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/rgbm_pkg.sv
hdl/rgbm_ram.sv
hdl/rgbm_median.sv
hdl/rgb_median3x3_filter_core.sv
hdl/rgbm_checker.sv
tb/rgb_median3x3_filter_core_tb.sv
